/* design/hsv_pkg.sv */
// Package: constants, types and fixed-point scale factors of the HSV to RGB converter.
`default_nettype none
package hsv_pkg;

    localparam int HUE_W        = 15;
    localparam int FRAC_W       = 9;
    localparam int CH_W         = 8;

    localparam int DEG_PER_SEXT = 60;
    localparam int HUE_PER_DEG  = 64;
    localparam int SEXTANT_SPAN = DEG_PER_SEXT * HUE_PER_DEG;      // 3840
    localparam int SEXTANTS     = 6;
    localparam int FULL_SCALE   = 255;
    localparam int ONE_FIX      = 256;
    localparam int FRAC_ONE     = SEXTANT_SPAN * ONE_FIX;          // 983040

    // largest quotient hue / SEXTANT_SPAN over the whole input range
    localparam int QUOT_MAX     = (2 ** HUE_W - 1) / SEXTANT_SPAN;
    localparam int QUOT_W       = $clog2(QUOT_MAX + 1);
    localparam int REM_W        = $clog2(SEXTANT_SPAN);

    localparam int SCALED_W     = 16;                              // brightness * 255
    localparam int WEIGHT_W     = $clog2(FRAC_ONE + 1);            // 20
    localparam int PROD_W       = SCALED_W + WEIGHT_W;             // 36

    // SEXTANT_SPAN * ONE_FIX * ONE_FIX = 15 * 2**24: shift by 24, then divide by 15
    localparam int COARSE_SHIFT = 24;
    localparam int COARSE_W     = PROD_W - COARSE_SHIFT;           // 12
    localparam int RECIP_DIV    = SEXTANT_SPAN / ONE_FIX;          // 15
    localparam int RECIP_SHIFT  = 16;
    localparam int RECIP_MUL    = (2 ** RECIP_SHIFT + RECIP_DIV - 1) / RECIP_DIV; // 4370
    localparam int RECIP_MUL_W  = $clog2(RECIP_MUL + 1);
    localparam int RECIP_PROD_W = COARSE_W + RECIP_MUL_W;

    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } sext_t;

endpackage
`default_nettype wire

/* design/hsv_to_rgb.sv */
// Top level: five-stage pipelined HSV to RGB pixel converter.
`default_nettype none
// hsv_to_rgb converts one HSV pixel per request into one RGB pixel. Hue is in
// 1/64 degree (0..23039), saturation and brightness are fixed point with 256
// meaning 1.0; values above 256 are clamped to 1.0. Each channel is truncated
// toward zero, and alpha is implicit (always 255). The block accepts one
// request every clock cycle while in_stall is low, and passes it through the five
// register stages: sextant split and value scaling, the hue-weight and p
// products, the q and t products, the reciprocal multiply that divides by 15,
// and the output register. All stages advance together; when the output holds
// a result that the receiver stalls, the whole pipeline holds and in_stall is
// raised. Nothing is lost or repeated across a stall.
module hsv_to_rgb (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [hsv_pkg::HUE_W-1:0]  hue,
    input  wire logic [hsv_pkg::FRAC_W-1:0] saturation,
    input  wire logic [hsv_pkg::FRAC_W-1:0] brightness,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [hsv_pkg::CH_W-1:0]        red,
    output logic [hsv_pkg::CH_W-1:0]        green,
    output logic [hsv_pkg::CH_W-1:0]        blue
);
    import hsv_pkg::*;

    logic advance;

    // stage 1: sextant, remainder, clamped saturation, scaled brightness
    logic                  s1_valid_reg;
    sext_t                 s1_sext_reg;
    logic [REM_W-1:0]      s1_rem_reg;
    logic [FRAC_W-1:0]     s1_sat_reg;
    logic [SCALED_W-1:0]   s1_scaled_reg;

    // stage 2: r * sat, sat * span, v and p
    logic                  s2_valid_reg;
    sext_t                 s2_sext_reg;
    logic [SCALED_W-1:0]   s2_scaled_reg;
    logic [WEIGHT_W-1:0]   s2_rs_reg;
    logic [WEIGHT_W-1:0]   s2_sspan_reg;
    logic [CH_W-1:0]       s2_v_reg;
    logic [CH_W-1:0]       s2_p_reg;

    // stage 3: coarse quotients of q and t
    logic                  s3_valid_reg;
    sext_t                 s3_sext_reg;
    logic [COARSE_W-1:0]   s3_cq_reg;
    logic [COARSE_W-1:0]   s3_ct_reg;
    logic [CH_W-1:0]       s3_v_reg;
    logic [CH_W-1:0]       s3_p_reg;

    // stage 4: reciprocal products
    logic                  s4_valid_reg;
    sext_t                 s4_sext_reg;
    logic [RECIP_PROD_W-1:0] s4_mq_reg;
    logic [RECIP_PROD_W-1:0] s4_mt_reg;
    logic [CH_W-1:0]       s4_v_reg;
    logic [CH_W-1:0]       s4_p_reg;

    // output stage
    logic                  out_valid_reg;
    logic [CH_W-1:0]       red_reg;
    logic [CH_W-1:0]       green_reg;
    logic [CH_W-1:0]       blue_reg;

    // hold every stage while a finished pixel waits at a stalled output
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // ---------------- stage 1 logic ----------------
    logic [QUOT_W-1:0]   quot;
    logic [HUE_W-1:0]    base;
    logic [HUE_W-1:0]    rem_full;
    logic [2:0]          sext_raw;
    logic [FRAC_W-1:0]   sat_clamped;
    logic [FRAC_W-1:0]   bri_clamped;
    logic [SCALED_W:0]   scaled_full;

    always_comb
    begin
        quot = '0;
        // count the sextant boundaries at or below the hue
        for (int k = 1; k <= QUOT_MAX; k++)
        begin
            if (hue >= HUE_W'(k * SEXTANT_SPAN))
            begin
                quot = quot + QUOT_W'(1);
            end
        end
        base     = HUE_W'(quot * SEXTANT_SPAN);
        rem_full = hue - base;
        // wrap the circle: quotients of six and above fold back
        if (quot >= QUOT_W'(SEXTANTS))
        begin
            sext_raw = 3'(quot - QUOT_W'(SEXTANTS));
        end
        else
        begin
            sext_raw = 3'(quot);
        end
        sat_clamped = (saturation > FRAC_W'(ONE_FIX)) ? FRAC_W'(ONE_FIX) : saturation;
        bri_clamped = (brightness > FRAC_W'(ONE_FIX)) ? FRAC_W'(ONE_FIX) : brightness;
        // brightness * 255 as (brightness << 8) - brightness
        scaled_full = {bri_clamped, 8'd0} - (SCALED_W+1)'(bri_clamped);
    end

    // ---------------- stage 2 logic ----------------
    logic [WEIGHT_W-1:0]            rs_prod;
    logic [FRAC_W-1:0]              sat_inv;
    logic [SCALED_W+FRAC_W-1:0]     p_prod;
    logic [WEIGHT_W-1:0]            sspan;

    always_comb
    begin
        rs_prod = WEIGHT_W'(s1_rem_reg) * WEIGHT_W'(s1_sat_reg);
        sat_inv = FRAC_W'(ONE_FIX) - s1_sat_reg;
        p_prod  = s1_scaled_reg * sat_inv;
        // sat * 3840 = (sat << 12) - (sat << 8)
        sspan   = WEIGHT_W'({s1_sat_reg, 12'd0}) - WEIGHT_W'({s1_sat_reg, 8'd0});
    end

    // ---------------- stage 3 logic ----------------
    logic [WEIGHT_W-1:0] wq;
    logic [WEIGHT_W:0]   wt_full;
    logic [PROD_W-1:0]   q_prod;
    logic [PROD_W-1:0]   t_prod;

    always_comb
    begin
        wq      = WEIGHT_W'(FRAC_ONE) - s2_rs_reg;
        wt_full = (WEIGHT_W+1)'(FRAC_ONE) - (WEIGHT_W+1)'(s2_sspan_reg)
                  + (WEIGHT_W+1)'(s2_rs_reg);
        q_prod  = s2_scaled_reg * wq;
        t_prod  = s2_scaled_reg * wt_full[WEIGHT_W-1:0];
    end

    // ---------------- stage 4 logic ----------------
    logic [RECIP_PROD_W-1:0] mq;
    logic [RECIP_PROD_W-1:0] mt;

    always_comb
    begin
        mq = s3_cq_reg * RECIP_MUL_W'(RECIP_MUL);
        mt = s3_ct_reg * RECIP_MUL_W'(RECIP_MUL);
    end

    // ---------------- output stage logic ----------------
    logic [CH_W-1:0] q_val;
    logic [CH_W-1:0] t_val;
    logic [CH_W-1:0] red_next;
    logic [CH_W-1:0] green_next;
    logic [CH_W-1:0] blue_next;

    always_comb
    begin
        q_val = s4_mq_reg[RECIP_SHIFT +: CH_W];
        t_val = s4_mt_reg[RECIP_SHIFT +: CH_W];
        // route v, p, q and t to the channels by sextant
        case (s4_sext_reg)
            SEXT_0:
            begin
                red_next = s4_v_reg; green_next = t_val;    blue_next = s4_p_reg;
            end
            SEXT_1:
            begin
                red_next = q_val;    green_next = s4_v_reg; blue_next = s4_p_reg;
            end
            SEXT_2:
            begin
                red_next = s4_p_reg; green_next = s4_v_reg; blue_next = t_val;
            end
            SEXT_3:
            begin
                red_next = s4_p_reg; green_next = q_val;    blue_next = s4_v_reg;
            end
            SEXT_4:
            begin
                red_next = t_val;    green_next = s4_p_reg; blue_next = s4_v_reg;
            end
            default:
            begin
                red_next = s4_v_reg; green_next = s4_p_reg; blue_next = q_val;
            end
        endcase
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sext_reg   <= sext_t'(sext_raw);
            s1_rem_reg    <= rem_full[REM_W-1:0];
            s1_sat_reg    <= sat_clamped;
            s1_scaled_reg <= scaled_full[SCALED_W-1:0];

            s2_sext_reg   <= s1_sext_reg;
            s2_scaled_reg <= s1_scaled_reg;
            s2_rs_reg     <= rs_prod;
            s2_sspan_reg  <= sspan;
            s2_v_reg      <= s1_scaled_reg[SCALED_W-1 -: CH_W];
            s2_p_reg      <= p_prod[SCALED_W +: CH_W];

            s3_sext_reg   <= s2_sext_reg;
            s3_cq_reg     <= q_prod[COARSE_SHIFT +: COARSE_W];
            s3_ct_reg     <= t_prod[COARSE_SHIFT +: COARSE_W];
            s3_v_reg      <= s2_v_reg;
            s3_p_reg      <= s2_p_reg;

            s4_sext_reg   <= s3_sext_reg;
            s4_mq_reg     <= mq;
            s4_mt_reg     <= mt;
            s4_v_reg      <= s3_v_reg;
            s4_p_reg      <= s3_p_reg;

            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule
`default_nettype wire

/* design/hsv_to_rgb_chk.sv */
// Checker: port-level assertions for hsv_to_rgb and its bind statement.
`default_nettype none
module hsv_to_rgb_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [14:0] hue,
    input wire logic [8:0]  saturation,
    input wire logic [8:0]  brightness,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  red,
    input wire logic [7:0]  green,
    input wire logic [7:0]  blue
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(red) && $stable(green)
                                      && $stable(blue)))
        else $error("stalled result changed");

    // stall the input only while a result is held at the output
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // drop all results during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // a grey request that is taken, with no output stall while it moves through the pipeline, comes out grey
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && saturation == 9'd0)
        ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> (out_valid && red == green && green == blue))
        else $error("zero saturation did not give a grey pixel");

endmodule

bind hsv_to_rgb hsv_to_rgb_chk u_hsv_to_rgb_chk (.*);
`default_nettype wire

/* test/tb_hsv_to_rgb.sv */
// Testbench for hsv_to_rgb: directed and random pixel requests checked against a local predictor.
`default_nettype none
module tb_hsv_to_rgb;
    import hsv_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int PIPE_LATENCY   = 5;
    localparam int STALL_PCT      = 38;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HUE_MAX        = SEXTANT_SPAN * SEXTANTS - 1;   // 23039

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_pixel_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [HUE_W-1:0]    hue        = '0;
    logic [FRAC_W-1:0]   saturation = '0;
    logic [FRAC_W-1:0]   brightness = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [CH_W-1:0]     red;
    logic [CH_W-1:0]     green;
    logic [CH_W-1:0]     blue;

    rgb_pixel_t          expected_pixels[$];
    rgb_pixel_t          oldest_pixel;
    int                  mismatches   = 0;
    int                  idle_pct     = STALL_PCT;
    int                  quiet_cycles = 0;

    hsv_to_rgb u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #(CLK_HALF) clk = ~clk;

    // Compute the RGB pixel for one HSV request. All products stay exact in 64 bits;
    // each channel is truncated toward zero by the integer division.
    function automatic rgb_pixel_t predict_pixel(input logic [HUE_W-1:0] h,
                                                 input logic [FRAC_W-1:0] s,
                                                 input logic [FRAC_W-1:0] b);
        longint unsigned sat;
        longint unsigned bri;
        longint unsigned rem;
        longint unsigned scaled;
        longint unsigned span_one;
        longint unsigned v;
        longint unsigned p;
        longint unsigned q;
        longint unsigned t;
        sext_t           sext;
        rgb_pixel_t      px;
        sat      = (s > ONE_FIX) ? ONE_FIX : s;
        bri      = (b > ONE_FIX) ? ONE_FIX : b;
        // hues past the circle wrap around through the modulo
        sext     = sext_t'((h / SEXTANT_SPAN) % SEXTANTS);
        rem      = h % SEXTANT_SPAN;
        scaled   = bri * FULL_SCALE;
        span_one = FRAC_ONE;
        v = scaled / ONE_FIX;
        p = (scaled * (ONE_FIX - sat)) / (ONE_FIX * ONE_FIX);
        q = (scaled * (span_one - rem * sat)) / (span_one * ONE_FIX);
        t = (scaled * (span_one - (SEXTANT_SPAN - rem) * sat)) / (span_one * ONE_FIX);
        case (sext)
            SEXT_0:  px = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
            SEXT_1:  px = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
            SEXT_2:  px = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
            SEXT_3:  px = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
            SEXT_4:  px = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
            default: px = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
        endcase
        return px;
    endfunction

    // Send one request: idle at random first, then hold the payload until accepted.
    task automatic send_pixel(input logic [HUE_W-1:0] h,
                              input logic [FRAC_W-1:0] s,
                              input logic [FRAC_W-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pixels.push_back(predict_pixel(h, s, b));
    endtask

    // Drop valid and hold off until every queued pixel has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Mostly in-range pixels, some right at sextant edges, some using the full field width.
    task automatic send_random_pixel();
        logic [HUE_W-1:0]  h;
        logic [FRAC_W-1:0] s;
        logic [FRAC_W-1:0] b;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            h = HUE_W'($urandom);
            s = FRAC_W'($urandom);
            b = FRAC_W'($urandom);
        end
        else if (pick < 27)
        begin
            h = HUE_W'(SEXTANT_SPAN * $urandom_range(1, SEXTANTS - 1) - 2 + $urandom_range(0, 3));
            s = FRAC_W'($urandom_range(0, ONE_FIX));
            b = FRAC_W'($urandom_range(0, ONE_FIX));
        end
        else
        begin
            h = HUE_W'($urandom_range(0, HUE_MAX));
            s = FRAC_W'($urandom_range(0, ONE_FIX));
            b = FRAC_W'($urandom_range(0, ONE_FIX));
        end
        send_pixel(h, s, b);
    endtask

    task automatic test_value_extremes();
        send_pixel(HUE_W'(0), FRAC_W'(0), FRAC_W'(0));
        send_pixel(HUE_W'(0), FRAC_W'(ONE_FIX), FRAC_W'(0));
        send_pixel(HUE_W'(0), FRAC_W'(0), FRAC_W'(ONE_FIX));
        send_pixel(HUE_W'(0), FRAC_W'(ONE_FIX), FRAC_W'(ONE_FIX));
        send_pixel(HUE_W'(11520), FRAC_W'(128), FRAC_W'(ONE_FIX));
        send_pixel(HUE_W'(5000), FRAC_W'(ONE_FIX), FRAC_W'(1));
    endtask

    // First and last hue of each sextant, where q and t reach their ends.
    task automatic test_sextant_edges();
        for (int k = 0; k < SEXTANTS; k++)
        begin
            send_pixel(HUE_W'(k * SEXTANT_SPAN), FRAC_W'(ONE_FIX), FRAC_W'(ONE_FIX));
            send_pixel(HUE_W'(k * SEXTANT_SPAN + SEXTANT_SPAN - 1), FRAC_W'(200),
                       FRAC_W'(255));
        end
    endtask

    // Hue past the circle wraps; saturation and brightness above 1.0 clamp.
    task automatic test_out_of_range();
        send_pixel(HUE_W'(23040), FRAC_W'(ONE_FIX), FRAC_W'(ONE_FIX));
        send_pixel({HUE_W{1'b1}}, {FRAC_W{1'b1}}, {FRAC_W{1'b1}});
        send_pixel(HUE_W'(30000), FRAC_W'(257), FRAC_W'(257));
        send_pixel(HUE_W'(1919), FRAC_W'(300), FRAC_W'(100));
    endtask

    // Long stretch with neither side idling: one request per cycle.
    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        for (int i = 0; i < count; i++)
            send_random_pixel();
        idle_pct = STALL_PCT;
    endtask

    task automatic test_pause_until_drained(input int count);
        for (int i = 0; i < count; i++)
            send_random_pixel();
        wait_for_drain();
        for (int i = 0; i < count; i++)
            send_random_pixel();
    endtask

    task automatic test_random_with_gaps(input int count);
        for (int i = 0; i < count; i++)
            send_random_pixel();
    endtask

    // Check each accepted result against the oldest prediction, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result red=%0d green=%0d blue=%0d", red, green, blue);
                mismatches++;
            end
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                if (red !== oldest_pixel.red)
                begin
                    $error("red: expected %0d, actual %0d", oldest_pixel.red, red);
                    mismatches++;
                end
                if (green !== oldest_pixel.green)
                begin
                    $error("green: expected %0d, actual %0d", oldest_pixel.green, green);
                    mismatches++;
                end
                if (blue !== oldest_pixel.blue)
                begin
                    $error("blue: expected %0d, actual %0d", oldest_pixel.blue, blue);
                    mismatches++;
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_value_extremes();
        test_sextant_edges();
        test_out_of_range();
        test_back_to_back(150);
        test_pause_until_drained(15);
        test_random_with_gaps(320);
        wait_for_drain();
        repeat (PIPE_LATENCY * 2) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
design/hsv_pkg.sv
design/hsv_to_rgb.sv
design/hsv_to_rgb_chk.sv
test/tb_hsv_to_rgb.sv
